### rtl/wbmp_monochrome_decoder_assert.svh
// Assertion macros used by the WBMP decoder top level.
`ifndef WBMP_MONOCHROME_DECODER_ASSERT_SVH
`define WBMP_MONOCHROME_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define WBMPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define WBMPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/wbmpd_pkg.sv
// Shared types and constants of the WBMP decoder.
package wbmpd_pkg;

  // Width of the internal size and position counters.
  localparam int DIM_BITS     = 16;
  // Width of the size and position fields on the result channel.
  localparam int OUT_DIM_W    = 16;
  localparam int PIX_PER_BYTE = 8;
  localparam int PIX_CNT_W    = $clog2(PIX_PER_BYTE + 1);
  localparam int PIX_IDX_W    = $clog2(PIX_PER_BYTE);

  typedef logic [DIM_BITS-1:0]  dim_t;
  typedef logic [PIX_CNT_W-1:0] pix_cnt_t;
  typedef logic [PIX_IDX_W-1:0] pix_idx_t;
  typedef logic [1:0]           kind_t;
  typedef logic [2:0]           err_t;

  localparam kind_t KIND_PIXEL = 2'd0;
  localparam kind_t KIND_SIZE  = 2'd1;
  localparam kind_t KIND_ERROR = 2'd2;

  localparam err_t ERR_NONE   = 3'd0;
  localparam err_t ERR_HEADER = 3'd1;
  localparam err_t ERR_TRUNC  = 3'd2;
  localparam err_t ERR_ZERO   = 3'd3;
  localparam err_t ERR_LARGE  = 3'd4;

  // One command from the parser to the result generator. It stands for
  // an optional size result, then pix_n pixels, then an optional error.
  typedef struct packed {
    logic     has_size;
    dim_t     width;
    dim_t     height;
    pix_cnt_t pix_n;
    logic [7:0] pix_byte;
    dim_t     x0;
    dim_t     y;
    logic     img_end;
    logic     has_err;
    err_t     err_code;
  } cmd_t;

  // Occupancy flags of the command queue.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

### rtl/wbmpd_if.sv
// Valid/ready channel interfaces of the WBMP decoder.
interface wbmpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbmpd_out_if;
  logic                                valid;
  logic                                ready;
  wbmpd_pkg::kind_t                    kind;
  logic [wbmpd_pkg::OUT_DIM_W-1:0]     pixel_x;
  logic [wbmpd_pkg::OUT_DIM_W-1:0]     pixel_y;
  logic [7:0]                          level;
  logic [7:0]                          alpha;
  logic [wbmpd_pkg::OUT_DIM_W-1:0]     image_width;
  logic [wbmpd_pkg::OUT_DIM_W-1:0]     image_height;
  wbmpd_pkg::err_t                     error_code;
  logic                                frame_end;
  logic                                run_last;

  modport source (output valid, output kind, output pixel_x, output pixel_y, output level,
                  output alpha, output image_width, output image_height, output error_code,
                  output frame_end, output run_last, input ready);
  modport sink (input valid, input kind, input pixel_x, input pixel_y, input level,
                input alpha, input image_width, input image_height, input error_code,
                input frame_end, input run_last, output ready);
endinterface

### rtl/wbmpd_front.sv
// Byte parser: header state machine, size decoding and pixel-run commands.
module wbmpd_front (
  input  logic                clk,
  input  logic                rst_n,
  wbmpd_in_if.sink            in_if,
  input  wbmpd_pkg::qstat_t   q_stat,
  output logic                q_push,
  output wbmpd_pkg::cmd_t     q_cmd
);

  typedef enum logic [2:0] {
    PH_TYPE   = 3'd0,
    PH_FIXHDR = 3'd1,
    PH_WIDTH  = 3'd2,
    PH_HEIGHT = 3'd3,
    PH_PIXELS = 3'd4,
    PH_DONE   = 3'd5,
    PH_SKIP   = 3'd6
  } phase_t;

  phase_t            phase_r, phase_nxt;
  wbmpd_pkg::dim_t   width_r, width_nxt;
  wbmpd_pkg::dim_t   height_r, height_nxt;
  wbmpd_pkg::dim_t   col_r, col_nxt;
  wbmpd_pkg::dim_t   row_r, row_nxt;

  logic                  in_accept;
  logic [7:0]            b;
  wbmpd_pkg::dim_t       left;
  wbmpd_pkg::pix_cnt_t   n;
  logic                  row_end;
  logic                  img_end;
  logic [wbmpd_pkg::DIM_BITS:0] row_inc;
  logic                  width_ovf;
  logic                  height_ovf;
  wbmpd_pkg::dim_t       width_shift;
  wbmpd_pkg::dim_t       height_shift;
  wbmpd_pkg::cmd_t       cmd;

  assign in_if.ready = !q_stat.full;
  assign in_accept   = in_if.valid && in_if.ready;
  assign b           = in_if.data_byte;

  // Seven more value bits may not push any set bit out of the counter.
  assign width_ovf    = width_r[wbmpd_pkg::DIM_BITS-1 -: 7] != 7'd0;
  assign height_ovf   = height_r[wbmpd_pkg::DIM_BITS-1 -: 7] != 7'd0;
  assign width_shift  = {width_r[wbmpd_pkg::DIM_BITS-8:0], b[6:0]};
  assign height_shift = {height_r[wbmpd_pkg::DIM_BITS-8:0], b[6:0]};

  assign left    = width_r - col_r;
  assign row_end = left <= wbmpd_pkg::dim_t'(wbmpd_pkg::PIX_PER_BYTE);
  assign n       = row_end ? left[wbmpd_pkg::PIX_CNT_W-1:0]
                           : wbmpd_pkg::pix_cnt_t'(wbmpd_pkg::PIX_PER_BYTE);
  assign row_inc = {1'b0, row_r} + {{wbmpd_pkg::DIM_BITS{1'b0}}, 1'b1};
  assign img_end = row_end && (row_inc >= {1'b0, height_r});

  always_comb begin
    phase_nxt  = phase_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    cmd        = '0;
    cmd.width  = width_r;
    cmd.height = height_r;
    cmd.pix_byte = b;

    unique case (phase_r)
      PH_TYPE, PH_FIXHDR: begin
        if (b != 8'd0) begin
          cmd.has_err  = 1'b1;
          cmd.err_code = wbmpd_pkg::ERR_HEADER;
          phase_nxt    = PH_SKIP;
        end else begin
          phase_nxt = (phase_r == PH_TYPE) ? PH_FIXHDR : PH_WIDTH;
        end
      end
      PH_WIDTH: begin
        if (width_ovf) begin
          cmd.has_err  = 1'b1;
          cmd.err_code = wbmpd_pkg::ERR_LARGE;
          phase_nxt    = PH_SKIP;
        end else begin
          width_nxt = width_shift;
          if (!b[7]) begin
            phase_nxt = PH_HEIGHT;
          end
        end
      end
      PH_HEIGHT: begin
        if (height_ovf) begin
          cmd.has_err  = 1'b1;
          cmd.err_code = wbmpd_pkg::ERR_LARGE;
          phase_nxt    = PH_SKIP;
        end else begin
          height_nxt = height_shift;
          if (!b[7]) begin
            if (width_r == '0 || height_shift == '0) begin
              cmd.has_err  = 1'b1;
              cmd.err_code = wbmpd_pkg::ERR_ZERO;
              phase_nxt    = PH_SKIP;
            end else begin
              cmd.has_size = 1'b1;
              cmd.height   = height_shift;
              phase_nxt    = PH_PIXELS;
              col_nxt      = '0;
              row_nxt      = '0;
            end
          end
        end
      end
      PH_PIXELS: begin
        if (in_if.last_byte && !img_end) begin
          cmd.has_err  = 1'b1;
          cmd.err_code = wbmpd_pkg::ERR_TRUNC;
          phase_nxt    = PH_SKIP;
        end else begin
          cmd.pix_n   = n;
          cmd.x0      = col_r;
          cmd.y       = height_r - wbmpd_pkg::dim_t'(1) - row_r;
          cmd.img_end = img_end;
          if (row_end) begin
            col_nxt = '0;
            row_nxt = row_inc[wbmpd_pkg::DIM_BITS-1:0];
            if (img_end) begin
              phase_nxt = PH_DONE;
            end
          end else begin
            col_nxt = col_r + wbmpd_pkg::dim_t'(n);
          end
        end
      end
      PH_DONE, PH_SKIP: begin
      end
      default: begin
      end
    endcase

    // The final byte of a file closes it out and rearms the parser.
    if (in_if.last_byte) begin
      if (phase_nxt != PH_DONE && phase_nxt != PH_SKIP) begin
        cmd.has_err  = 1'b1;
        cmd.err_code = wbmpd_pkg::ERR_TRUNC;
      end
      phase_nxt  = PH_TYPE;
      width_nxt  = '0;
      height_nxt = '0;
      col_nxt    = '0;
      row_nxt    = '0;
    end
  end

  assign q_cmd  = cmd;
  assign q_push = in_accept && (cmd.has_size || cmd.has_err || cmd.pix_n != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      width_r  <= '0;
      height_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else if (in_accept) begin
      phase_r  <= phase_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

### rtl/wbmpd_cmd_queue.sv
// Two-entry command queue between the parser and the result generator.
module wbmpd_cmd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wbmpd_pkg::cmd_t     push_cmd,
  input  logic                pop,
  output wbmpd_pkg::cmd_t     head_cmd,
  output wbmpd_pkg::qstat_t   stat
);

  wbmpd_pkg::cmd_t slot_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;

  assign head_cmd   = slot_r[rd_ptr_r];
  assign stat.full  = count_r == 2'd2;
  assign stat.empty = count_r == 2'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

### rtl/wbmpd_back.sv
// Result generator: expands commands into results, one per cycle while the receiver is ready.
module wbmpd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          alpha_value,
  input  wbmpd_pkg::cmd_t     head_cmd,
  input  wbmpd_pkg::qstat_t   q_stat,
  output logic                q_pop,
  wbmpd_out_if.source         out_if
);

  typedef enum logic [1:0] {
    ST_SIZE = 2'd0,
    ST_PIX  = 2'd1,
    ST_ERR  = 2'd2
  } step_t;

  typedef struct packed {
    wbmpd_pkg::kind_t              kind;
    logic [wbmpd_pkg::OUT_DIM_W-1:0] pixel_x;
    logic [wbmpd_pkg::OUT_DIM_W-1:0] pixel_y;
    logic [7:0]                    level;
    logic [7:0]                    alpha;
    logic [wbmpd_pkg::OUT_DIM_W-1:0] image_width;
    logic [wbmpd_pkg::OUT_DIM_W-1:0] image_height;
    wbmpd_pkg::err_t               error_code;
    logic                          frame_end;
    logic                          run_last;
  } res_t;

  wbmpd_pkg::cmd_t    cur_r;
  logic               cur_valid_r;
  step_t              step_r, step_nxt, step_first;
  wbmpd_pkg::pix_idx_t idx_r, idx_nxt;
  logic               out_valid_r;
  res_t               out_r, res;

  logic               advance;
  logic               is_last;
  logic               last_pix;
  logic [7:0]         shifted;

  assign shifted  = cur_r.pix_byte << idx_r;
  assign last_pix = ({1'b0, idx_r} + wbmpd_pkg::pix_cnt_t'(1)) == cur_r.pix_n;

  always_comb begin
    res      = '0;
    is_last  = 1'b1;
    step_nxt = step_r;
    idx_nxt  = idx_r;
    unique case (step_r)
      ST_SIZE: begin
        res.kind         = wbmpd_pkg::KIND_SIZE;
        res.image_width  = wbmpd_pkg::OUT_DIM_W'(cur_r.width);
        res.image_height = wbmpd_pkg::OUT_DIM_W'(cur_r.height);
        is_last          = cur_r.pix_n == '0 && !cur_r.has_err;
        step_nxt         = (cur_r.pix_n != '0) ? ST_PIX : ST_ERR;
        idx_nxt          = '0;
      end
      ST_PIX: begin
        res.kind      = wbmpd_pkg::KIND_PIXEL;
        res.pixel_x   = wbmpd_pkg::OUT_DIM_W'(cur_r.x0 + wbmpd_pkg::dim_t'(idx_r));
        res.pixel_y   = wbmpd_pkg::OUT_DIM_W'(cur_r.y);
        res.level     = shifted[7] ? 8'hff : 8'h00;
        res.alpha     = alpha_value;
        res.frame_end = cur_r.img_end && last_pix;
        is_last       = last_pix && !cur_r.has_err;
        if (last_pix) begin
          step_nxt = ST_ERR;
        end else begin
          idx_nxt = idx_r + wbmpd_pkg::pix_idx_t'(1);
        end
      end
      ST_ERR: begin
        res.kind       = wbmpd_pkg::KIND_ERROR;
        res.error_code = cur_r.err_code;
      end
      default: begin
      end
    endcase
    res.run_last = is_last;
  end

  // A command starts at its first nonempty part.
  always_comb begin
    if (head_cmd.has_size) begin
      step_first = ST_SIZE;
    end else if (head_cmd.pix_n != '0) begin
      step_first = ST_PIX;
    end else begin
      step_first = ST_ERR;
    end
  end

  assign advance = cur_valid_r && (!out_valid_r || out_if.ready);
  assign q_pop   = !q_stat.empty && (!cur_valid_r || (advance && is_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= ST_SIZE;
      idx_r       <= '0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        step_r      <= step_first;
        idx_r       <= '0;
      end else if (advance) begin
        cur_valid_r <= !is_last;
        step_r      <= step_nxt;
        idx_r       <= idx_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= head_cmd;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = out_r.kind;
  assign out_if.pixel_x      = out_r.pixel_x;
  assign out_if.pixel_y      = out_r.pixel_y;
  assign out_if.level        = out_r.level;
  assign out_if.alpha        = out_r.alpha;
  assign out_if.image_width  = out_r.image_width;
  assign out_if.image_height = out_r.image_height;
  assign out_if.error_code   = out_r.error_code;
  assign out_if.frame_end    = out_r.frame_end;
  assign out_if.run_last     = out_r.run_last;

endmodule

### rtl/wbmp_monochrome_decoder.sv
// Top level of the WBMP type-0 decoder: parser, command queue, result generator.
// The input channel takes one byte of a WBMP type-0 file per transfer, with
// last_byte set on the final byte of the file; the block then rearms for the next file.
// The result channel gives one transfer per result: an image size when the height
// field ends, pixels MSB first with rows numbered bottom-up, or an error code.
// run_last marks the last result caused by one input byte, frame_end the final pixel.
// cfg_we writes cfg_wdata into the alpha register, which reset sets to 255; the user
// must write it only while no file byte is in flight, as the block does not enforce this.
// Each result passes the command queue, the command register and the result register.
// A pixel byte gives one result per pixel it carries, so up to eight, and the
// single result register emits one result per cycle while the receiver is ready.
// The parser runs ahead through a two-entry queue.
// A stalled receiver holds the result register; once the queue fills,
// in_if.ready drops until the generator frees an entry.
// Reset (rst_n low at a clock edge) empties the queue and returns the parser
// to the start of a file.
`include "wbmp_monochrome_decoder_assert.svh"

module wbmp_monochrome_decoder (
  input  logic        clk,
  input  logic        rst_n,
  wbmpd_in_if.sink    in_if,
  wbmpd_out_if.source out_if,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam logic [7:0] ALPHA_RESET = 8'hff;

  logic [7:0]          alpha_r;
  logic                q_push;
  logic                q_pop;
  wbmpd_pkg::cmd_t     q_cmd;
  wbmpd_pkg::cmd_t     head_cmd;
  wbmpd_pkg::qstat_t   q_stat;

  // The alpha register is plain configuration; it survives the end of a file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
    end else if (cfg_we) begin
      alpha_r <= cfg_wdata;
    end
  end

  // The parser classifies each byte and queues a command only when the
  // byte causes at least one result.
  wbmpd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  wbmpd_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  // The generator walks each command: size, then pixels, then error.
  wbmpd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .alpha_value (alpha_r),
    .head_cmd    (head_cmd),
    .q_stat      (q_stat),
    .q_pop       (q_pop),
    .out_if      (out_if)
  );

  `WBMPD_ASSERT_SAME(a_queue_no_overflow, q_push, !q_stat.full, "command pushed into a full queue")
  `WBMPD_ASSERT_NEXT(a_queue_fills, q_push && q_stat.empty, !q_stat.empty, "pushed command was lost")
  `WBMPD_ASSERT_SAME(a_frame_end_pixel, out_if.valid && out_if.frame_end, out_if.kind == wbmpd_pkg::KIND_PIXEL && out_if.run_last, "frame end on a non-pixel or non-final result")
  `WBMPD_ASSERT_SAME(a_error_has_code, out_if.valid && out_if.kind == wbmpd_pkg::KIND_ERROR, out_if.error_code != wbmpd_pkg::ERR_NONE && out_if.run_last, "error result without a code or not last")

endmodule
